>>> rtl/core/ludpp_pkg.sv
// Shared types, constants and command structures of the LU decomposition block.
package ludpp_pkg;

  localparam int MAX_N_DEF     = 8;
  localparam int FRAC_BITS_DEF = 16;
  localparam int IDX_W         = 3;
  localparam int SIZE_W        = 4;
  localparam int DATA_W        = 32;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;
  localparam logic [1:0] REG_MATRIX_SIZE = 2'd0;

  typedef logic [IDX_W-1:0] idx_t;

  typedef enum logic [2:0] {
    WS_IN,
    WS_A,
    WS_B,
    WS_DIV,
    WS_UPD
  } wsel_t;

  typedef enum logic [1:0] {
    OS_IDX,
    OS_A,
    OS_B
  } osel_t;

  typedef struct packed {
    logic  ren;
    idx_t  a_row;
    idx_t  a_col;
    idx_t  b_row;
    idx_t  b_col;
    logic  we;
    wsel_t wsel;
    idx_t  w_row;
    idx_t  w_col;
    logic  o_ren;
    idx_t  o_a;
    idx_t  o_b;
    logic  o_we;
    osel_t o_wsel;
    idx_t  o_w;
    logic  best_ld;
    logic  best_cmp;
    idx_t  k;
    logic  par_clr;
    logic  par_tgl;
    logic  halt_set;
    logic  div_start;
    logic  mul_go;
    logic  term_go;
  } cmd_t;

  typedef struct packed {
    idx_t piv;
    logic piv_zero;
    logic div_done;
  } stat_t;

endpackage

>>> rtl/core/ludpp_ram.sv
// Generic RAM with one write port and two registered read ports.
module ludpp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     ren,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (ren) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

>>> rtl/core/ludpp_div.sv
// Bit-serial signed fixed-point divider with saturation to 32 bits.
module ludpp_div #(
  parameter int FRAC_BITS = ludpp_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] num,
  input  logic [31:0] den,
  output logic        done,
  output logic [31:0] q
);
  localparam int NW = 32 + FRAC_BITS;
  localparam int CW = $clog2(NW + 1);
  localparam logic [NW-1:0] LIM_P = NW'(64'h7FFF_FFFF);
  localparam logic [NW-1:0] LIM_N = NW'(64'h8000_0000);

  logic          busy_r, busy_nxt;
  logic          fin_r, fin_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          neg_r, neg_nxt;
  logic [NW-1:0] nbits_r, nbits_nxt;
  logic [NW-1:0] quot_r, quot_nxt;
  logic [31:0]   d_r, d_nxt;
  logic [31:0]   rem_r, rem_nxt;
  logic [31:0]   q_r, q_nxt;
  logic [31:0]   num_mag, den_mag;
  logic [32:0]   trial;

  assign num_mag = num[31] ? (~num + 32'd1) : num;
  assign den_mag = den[31] ? (~den + 32'd1) : den;
  assign trial   = {rem_r, nbits_r[NW-1]};

  always_comb begin
    busy_nxt  = busy_r;
    fin_nxt   = 1'b0;
    done_nxt  = 1'b0;
    cnt_nxt   = cnt_r;
    neg_nxt   = neg_r;
    nbits_nxt = nbits_r;
    quot_nxt  = quot_r;
    d_nxt     = d_r;
    rem_nxt   = rem_r;
    q_nxt     = q_r;
    if (start) begin
      busy_nxt  = 1'b1;
      cnt_nxt   = CW'(NW);
      neg_nxt   = num[31] ^ den[31];
      nbits_nxt = NW'(num_mag) << FRAC_BITS;
      quot_nxt  = '0;
      d_nxt     = den_mag;
      rem_nxt   = '0;
    end else if (busy_r) begin
      if (trial >= {1'b0, d_r}) begin
        rem_nxt  = 32'(trial - {1'b0, d_r});
        quot_nxt = {quot_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt  = trial[31:0];
        quot_nxt = {quot_r[NW-2:0], 1'b0};
      end
      nbits_nxt = {nbits_r[NW-2:0], 1'b0};
      cnt_nxt   = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        fin_nxt  = 1'b1;
      end
    end else if (fin_r) begin
      done_nxt = 1'b1;
      if (neg_r) begin
        q_nxt = (quot_r > LIM_N) ? 32'h8000_0000 : (~quot_r[31:0] + 32'd1);
      end else begin
        q_nxt = (quot_r > LIM_P) ? 32'h7FFF_FFFF : quot_r[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      fin_r  <= fin_nxt;
      done_r <= done_nxt;
    end
    cnt_r   <= cnt_nxt;
    neg_r   <= neg_nxt;
    nbits_r <= nbits_nxt;
    quot_r  <= quot_nxt;
    d_r     <= d_nxt;
    rem_r   <= rem_nxt;
    q_r     <= q_nxt;
  end

  assign done = done_r;
  assign q    = q_r;

endmodule

>>> rtl/core/ludpp_ctrl.sv
// Controller: load, pivot search, swap, elimination and emission sequencing.
module ludpp_ctrl #(
  parameter int MAX_N = ludpp_pkg::MAX_N_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output ludpp_pkg::idx_t   out_row,
  output ludpp_pkg::idx_t   out_col,
  output logic              out_last,
  input  logic              cfg_wr,
  input  logic [3:0]        cfg_size,
  output logic [3:0]        size_q,
  output ludpp_pkg::cmd_t   cmd,
  input  ludpp_pkg::stat_t  st
);
  import ludpp_pkg::*;

  typedef enum logic [18:0] {
    S_LOAD = 19'h00001,
    S_INIT = 19'h00002,
    S_PSR  = 19'h00004,
    S_PSC  = 19'h00008,
    S_SWD  = 19'h00010,
    S_SO1  = 19'h00020,
    S_SO2  = 19'h00040,
    S_SXR  = 19'h00080,
    S_SX1  = 19'h00100,
    S_SX2  = 19'h00200,
    S_MR   = 19'h00400,
    S_MD   = 19'h00800,
    S_MW   = 19'h01000,
    S_UR   = 19'h02000,
    S_UM   = 19'h04000,
    S_UT   = 19'h08000,
    S_UW   = 19'h10000,
    S_ER   = 19'h20000,
    S_EV   = 19'h40000
  } state_t;

  localparam logic [SIZE_W-1:0] NMAX  = SIZE_W'(MAX_N);
  localparam logic [SIZE_W-1:0] LASTE = SIZE_W'(MAX_N - 1);

  state_t            state_r, state_nxt;
  logic [SIZE_W-1:0] size_r, size_nxt;
  logic [SIZE_W-1:0] ldr_r, ldr_nxt, ldc_r, ldc_nxt;
  logic [SIZE_W-1:0] i_r, i_nxt, k_r, k_nxt, l_r, l_nxt, j_r, j_nxt;
  logic [SIZE_W-1:0] n, nm1;

  always_comb begin
    if (size_r == '0) begin
      n = SIZE_W'(1);
    end else if (size_r > NMAX) begin
      n = NMAX;
    end else begin
      n = size_r;
    end
  end
  assign nm1 = n - SIZE_W'(1);

  always_comb begin
    state_nxt = state_r;
    size_nxt  = size_r;
    ldr_nxt   = ldr_r;
    ldc_nxt   = ldc_r;
    i_nxt     = i_r;
    k_nxt     = k_r;
    l_nxt     = l_r;
    j_nxt     = j_r;
    cmd        = '0;
    cmd.wsel   = WS_IN;
    cmd.o_wsel = OS_IDX;
    cmd.k      = k_r[IDX_W-1:0];
    unique case (state_r)
      S_LOAD: begin
        cmd.w_row = ldr_r[IDX_W-1:0];
        cmd.w_col = ldc_r[IDX_W-1:0];
        if (in_valid) begin
          cmd.we = 1'b1;
          if (ldc_r == nm1) begin
            ldc_nxt = '0;
            if (ldr_r == nm1) begin
              ldr_nxt   = '0;
              k_nxt     = '0;
              state_nxt = S_INIT;
            end else begin
              ldr_nxt = ldr_r + SIZE_W'(1);
            end
          end else begin
            ldc_nxt = ldc_r + SIZE_W'(1);
          end
        end
      end
      S_INIT: begin
        cmd.o_we    = 1'b1;
        cmd.o_wsel  = OS_IDX;
        cmd.o_w     = k_r[IDX_W-1:0];
        cmd.par_clr = 1'b1;
        if (k_r == LASTE) begin
          i_nxt = '0;
          k_nxt = '0;
          l_nxt = '0;
          j_nxt = '0;
          state_nxt = (n == SIZE_W'(1)) ? S_ER : S_PSR;
        end else begin
          k_nxt = k_r + SIZE_W'(1);
        end
      end
      S_PSR: begin
        cmd.ren   = 1'b1;
        cmd.a_row = k_r[IDX_W-1:0];
        cmd.a_col = i_r[IDX_W-1:0];
        state_nxt = S_PSC;
      end
      S_PSC: begin
        cmd.best_ld  = (k_r == i_r);
        cmd.best_cmp = (k_r != i_r);
        if (k_r == nm1) begin
          state_nxt = S_SWD;
        end else begin
          k_nxt     = k_r + SIZE_W'(1);
          state_nxt = S_PSR;
        end
      end
      S_SWD: begin
        if (st.piv == i_r[IDX_W-1:0]) begin
          l_nxt     = i_r + SIZE_W'(1);
          state_nxt = S_MR;
        end else begin
          cmd.par_tgl = 1'b1;
          cmd.o_ren   = 1'b1;
          cmd.o_a     = i_r[IDX_W-1:0];
          cmd.o_b     = st.piv;
          j_nxt       = '0;
          state_nxt   = S_SO1;
        end
      end
      S_SO1: begin
        cmd.o_we   = 1'b1;
        cmd.o_wsel = OS_B;
        cmd.o_w    = i_r[IDX_W-1:0];
        state_nxt  = S_SO2;
      end
      S_SO2: begin
        cmd.o_we   = 1'b1;
        cmd.o_wsel = OS_A;
        cmd.o_w    = st.piv;
        state_nxt  = S_SXR;
      end
      S_SXR: begin
        cmd.ren   = 1'b1;
        cmd.a_row = i_r[IDX_W-1:0];
        cmd.a_col = j_r[IDX_W-1:0];
        cmd.b_row = st.piv;
        cmd.b_col = j_r[IDX_W-1:0];
        state_nxt = S_SX1;
      end
      S_SX1: begin
        cmd.we    = 1'b1;
        cmd.wsel  = WS_B;
        cmd.w_row = i_r[IDX_W-1:0];
        cmd.w_col = j_r[IDX_W-1:0];
        state_nxt = S_SX2;
      end
      S_SX2: begin
        cmd.we    = 1'b1;
        cmd.wsel  = WS_A;
        cmd.w_row = st.piv;
        cmd.w_col = j_r[IDX_W-1:0];
        if (j_r == nm1) begin
          l_nxt     = i_r + SIZE_W'(1);
          state_nxt = S_MR;
        end else begin
          j_nxt     = j_r + SIZE_W'(1);
          state_nxt = S_SXR;
        end
      end
      S_MR: begin
        cmd.ren   = 1'b1;
        cmd.a_row = l_r[IDX_W-1:0];
        cmd.a_col = i_r[IDX_W-1:0];
        cmd.b_row = i_r[IDX_W-1:0];
        cmd.b_col = i_r[IDX_W-1:0];
        state_nxt = S_MD;
      end
      S_MD: begin
        if (st.piv_zero) begin
          cmd.halt_set = 1'b1;
          l_nxt        = '0;
          j_nxt        = '0;
          state_nxt    = S_ER;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = S_MW;
        end
      end
      S_MW: begin
        cmd.wsel  = WS_DIV;
        cmd.w_row = l_r[IDX_W-1:0];
        cmd.w_col = i_r[IDX_W-1:0];
        if (st.div_done) begin
          cmd.we    = 1'b1;
          j_nxt     = i_r + SIZE_W'(1);
          state_nxt = S_UR;
        end
      end
      S_UR: begin
        cmd.ren   = 1'b1;
        cmd.a_row = i_r[IDX_W-1:0];
        cmd.a_col = j_r[IDX_W-1:0];
        cmd.b_row = l_r[IDX_W-1:0];
        cmd.b_col = j_r[IDX_W-1:0];
        state_nxt = S_UM;
      end
      S_UM: begin
        cmd.mul_go = 1'b1;
        state_nxt  = S_UT;
      end
      S_UT: begin
        cmd.term_go = 1'b1;
        state_nxt   = S_UW;
      end
      S_UW: begin
        cmd.we    = 1'b1;
        cmd.wsel  = WS_UPD;
        cmd.w_row = l_r[IDX_W-1:0];
        cmd.w_col = j_r[IDX_W-1:0];
        if (j_r != nm1) begin
          j_nxt     = j_r + SIZE_W'(1);
          state_nxt = S_UR;
        end else if (l_r != nm1) begin
          l_nxt     = l_r + SIZE_W'(1);
          state_nxt = S_MR;
        end else if (i_r == n - SIZE_W'(2)) begin
          l_nxt     = '0;
          j_nxt     = '0;
          state_nxt = S_ER;
        end else begin
          i_nxt     = i_r + SIZE_W'(1);
          k_nxt     = i_r + SIZE_W'(1);
          state_nxt = S_PSR;
        end
      end
      S_ER: begin
        cmd.ren   = 1'b1;
        cmd.a_row = l_r[IDX_W-1:0];
        cmd.a_col = j_r[IDX_W-1:0];
        cmd.o_ren = 1'b1;
        cmd.o_b   = l_r[IDX_W-1:0];
        state_nxt = S_EV;
      end
      S_EV: begin
        if (!out_stall) begin
          if (j_r == nm1) begin
            j_nxt = '0;
            if (l_r == nm1) begin
              state_nxt = S_LOAD;
            end else begin
              l_nxt     = l_r + SIZE_W'(1);
              state_nxt = S_ER;
            end
          end else begin
            j_nxt     = j_r + SIZE_W'(1);
            state_nxt = S_ER;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
    if (cfg_wr) begin
      size_nxt = cfg_size;
      ldr_nxt  = '0;
      ldc_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      size_r  <= SIZE_RESET;
      ldr_r   <= '0;
      ldc_r   <= '0;
      i_r     <= '0;
      k_r     <= '0;
      l_r     <= '0;
      j_r     <= '0;
    end else begin
      state_r <= state_nxt;
      size_r  <= size_nxt;
      ldr_r   <= ldr_nxt;
      ldc_r   <= ldc_nxt;
      i_r     <= i_nxt;
      k_r     <= k_nxt;
      l_r     <= l_nxt;
      j_r     <= j_nxt;
    end
  end

  assign in_stall  = (state_r != S_LOAD);
  assign out_valid = (state_r == S_EV);
  assign out_row   = l_r[IDX_W-1:0];
  assign out_col   = j_r[IDX_W-1:0];
  assign out_last  = (l_r == nm1) && (j_r == nm1);
  assign size_q    = size_r;

endmodule

>>> rtl/core/ludpp_dp.sv
// Datapath: matrix store, row origin store, pivot compare, divider and update arithmetic.
module ludpp_dp #(
  parameter int MAX_N     = ludpp_pkg::MAX_N_DEF,
  parameter int FRAC_BITS = ludpp_pkg::FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  ludpp_pkg::cmd_t         cmd,
  input  logic [31:0]             in_value,
  output ludpp_pkg::stat_t        st,
  output logic [31:0]             lu_value,
  output ludpp_pkg::idx_t         source_row,
  output logic                    odd_swaps,
  output logic                    stopped_early
);
  import ludpp_pkg::*;

  localparam int AW  = $clog2(MAX_N * MAX_N);
  localparam int OAW = $clog2(MAX_N);
  localparam logic signed [63:0] P_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] P_MIN = -64'sh0000_0000_8000_0000;

  function automatic logic [AW-1:0] saddr(input idx_t r, input idx_t c);
    return AW'(int'(r) * MAX_N + int'(c));
  endfunction

  logic [31:0]    rd_a, rd_b, wdata;
  logic [OAW-1:0] o_rd_a, o_rd_b, o_wdata;
  logic [32:0]    ext_a, mag_a;
  logic [32:0]    best_r, best_nxt;
  idx_t           piv_r, piv_nxt;
  logic           par_r, par_nxt, halt_r, halt_nxt;
  logic           div_done;
  logic [31:0]    div_q;
  logic signed [63:0] prod_r, sh;
  logic [31:0]    term_r, term_nxt;
  logic signed [32:0] diff;
  logic [31:0]    upd;

  assign ext_a = {rd_a[31], rd_a};
  assign mag_a = ext_a[32] ? (~ext_a + 33'd1) : ext_a;

  assign sh   = prod_r >>> FRAC_BITS;
  assign diff = $signed({rd_b[31], rd_b}) - $signed({term_r[31], term_r});

  always_comb begin
    if (diff[32] != diff[31]) begin
      upd = diff[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      upd = diff[31:0];
    end
    if (sh > P_MAX) begin
      term_nxt = 32'h7FFF_FFFF;
    end else if (sh < P_MIN) begin
      term_nxt = 32'h8000_0000;
    end else begin
      term_nxt = sh[31:0];
    end
  end

  always_comb begin
    unique case (cmd.wsel)
      WS_IN:   wdata = in_value;
      WS_A:    wdata = rd_a;
      WS_B:    wdata = rd_b;
      WS_DIV:  wdata = div_q;
      WS_UPD:  wdata = upd;
      default: wdata = in_value;
    endcase
    unique case (cmd.o_wsel)
      OS_IDX:  o_wdata = cmd.o_w[OAW-1:0];
      OS_A:    o_wdata = o_rd_a;
      OS_B:    o_wdata = o_rd_b;
      default: o_wdata = cmd.o_w[OAW-1:0];
    endcase
  end

  always_comb begin
    best_nxt = best_r;
    piv_nxt  = piv_r;
    par_nxt  = par_r;
    halt_nxt = halt_r;
    if (cmd.best_ld || (cmd.best_cmp && (mag_a > best_r))) begin
      best_nxt = mag_a;
      piv_nxt  = cmd.k;
    end
    if (cmd.par_clr) begin
      par_nxt  = 1'b0;
      halt_nxt = 1'b0;
    end
    if (cmd.par_tgl) begin
      par_nxt = ~par_r;
    end
    if (cmd.halt_set) begin
      halt_nxt = 1'b1;
    end
  end

  ludpp_ram #(.WIDTH(32), .DEPTH(MAX_N * MAX_N)) u_store (
    .clk     (clk),
    .we      (cmd.we),
    .waddr   (saddr(cmd.w_row, cmd.w_col)),
    .wdata   (wdata),
    .ren     (cmd.ren),
    .raddr_a (saddr(cmd.a_row, cmd.a_col)),
    .raddr_b (saddr(cmd.b_row, cmd.b_col)),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  ludpp_ram #(.WIDTH(OAW), .DEPTH(MAX_N)) u_origin (
    .clk     (clk),
    .we      (cmd.o_we),
    .waddr   (cmd.o_w[OAW-1:0]),
    .wdata   (o_wdata),
    .ren     (cmd.o_ren),
    .raddr_a (cmd.o_a[OAW-1:0]),
    .raddr_b (cmd.o_b[OAW-1:0]),
    .rdata_a (o_rd_a),
    .rdata_b (o_rd_b)
  );

  ludpp_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (rd_a),
    .den   (rd_b),
    .done  (div_done),
    .q     (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      par_r  <= 1'b0;
      halt_r <= 1'b0;
    end else begin
      par_r  <= par_nxt;
      halt_r <= halt_nxt;
    end
    best_r <= best_nxt;
    piv_r  <= piv_nxt;
    if (cmd.mul_go) begin
      prod_r <= $signed(div_q) * $signed(rd_a);
    end
    if (cmd.term_go) begin
      term_r <= term_nxt;
    end
  end

  assign st.piv        = piv_r;
  assign st.piv_zero   = (rd_b == '0);
  assign st.div_done   = div_done;
  assign lu_value      = rd_a;
  assign source_row    = IDX_W'(o_rd_b);
  assign odd_swaps     = par_r;
  assign stopped_early = halt_r;

endmodule

>>> rtl/core/lu_decompose_partial_pivot_top.sv
// Top level of the LU decomposition block with partial pivoting.
//
//  Channel  Direction  Handshake          Payload
//  in       input      in_valid/in_stall  in_element_value
//  out      output     out_valid/out_stall row, col, value, source row, flags
//  cfg      APB write  psel/penable/pready matrix_size at byte address 0
//
// Loading takes one item per cycle, n*n items in row-major order.
// Elimination is bounded by the bit-serial divider, run once per multiplier,
// and by the read, multiply, term and write steps of each trailing update.
// Emission reads each result item, then offers it until out_stall is low.
// Reset is synchronous and active low; no items are taken while results are out.
module lu_decompose_partial_pivot_top #(
  parameter int MAX_N     = ludpp_pkg::MAX_N_DEF,
  parameter int FRAC_BITS = ludpp_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_element_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_row_index,
  output logic [2:0]  out_col_index,
  output logic [31:0] out_lu_value,
  output logic [2:0]  out_source_row,
  output logic        out_odd_swaps,
  output logic        out_stopped_early,
  output logic        out_last_of_run,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import ludpp_pkg::*;

  cmd_t       cmd;
  stat_t      st;
  logic       cfg_wr;
  logic [3:0] size_q;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                      && ({1'b0, cfg_paddr[2]} == REG_MATRIX_SIZE);
  assign cfg_prdata = ({1'b0, cfg_paddr[2]} == REG_MATRIX_SIZE) ? {28'd0, size_q} : 32'd0;

  ludpp_ctrl #(.MAX_N(MAX_N)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_row   (out_row_index),
    .out_col   (out_col_index),
    .out_last  (out_last_of_run),
    .cfg_wr    (cfg_wr),
    .cfg_size  (cfg_pwdata[3:0]),
    .size_q    (size_q),
    .cmd       (cmd),
    .st        (st)
  );

  ludpp_dp #(.MAX_N(MAX_N), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .in_value      (in_element_value),
    .st            (st),
    .lu_value      (out_lu_value),
    .source_row    (out_source_row),
    .odd_swaps     (out_odd_swaps),
    .stopped_early (out_stopped_early)
  );

endmodule

>>> rtl/core/ludpp_chk.sv
// Port-level checker for the LU decomposition block, bound to the top level.
module ludpp_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_last_of_run,
  input logic [31:0] out_lu_value,
  input logic        cfg_pready
);

  a_no_in_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken while a result item is offered");

  a_gap_after_item: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall) |=> !out_valid)
    else $error("result valid straight after a taken item");

  a_load_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_last_of_run) |=> !in_stall)
    else $error("input not open after the last result item");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_lu_value)))
    else $error("stalled result item changed");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_pready)
    else $error("pready low");

endmodule

bind lu_decompose_partial_pivot_top ludpp_chk u_chk (.*);
